>>> rtl/sltab_pkg.sv
package sltab_pkg;

	localparam int CAPACITY = 16;
	localparam int KEY_W    = 32;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int MODE_W   = 3;
	localparam int STAT_W   = 2;

	localparam int S_TDATA_W = ((KEY_W + 7) / 8) * 8;
	localparam int M_TDATA_W = ((KEY_W + CNT_W + 1 + 7) / 8) * 8;
	localparam int M_TUSER_W = STAT_W + 1;

	localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
	localparam logic [MODE_W-1:0] MODE_DELETE = 3'd1;
	localparam logic [MODE_W-1:0] MODE_LOOKUP = 3'd2;
	localparam logic [MODE_W-1:0] MODE_REWIND = 3'd3;
	localparam logic [MODE_W-1:0] MODE_NEXT   = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [STAT_W-1:0] ST_AT_END    = 2'd3;

	// broadcast to every cell
	typedef struct packed {
		logic                    ins;
		logic                    del;
		logic signed [KEY_W-1:0] key;
	} sltab_cmd_t;

	// per-cell compare results
	typedef struct packed {
		logic place;  // empty or greater than key: at or past insert point
		logic ge;     // holds a key not less than key
		logic eq;     // holds a key equal to key
	} sltab_flags_t;

endpackage

>>> rtl/sltab_cell.sv
module sltab_cell (
	input  logic                            clk,
	input  sltab_pkg::sltab_cmd_t           cmd,
	input  logic                            is_valid,
	input  logic signed [sltab_pkg::KEY_W-1:0] left_key,
	input  logic                            left_place,
	input  logic signed [sltab_pkg::KEY_W-1:0] right_key,
	output logic signed [sltab_pkg::KEY_W-1:0] key_q,
	output sltab_pkg::sltab_flags_t         flags
);

	always_comb begin
		flags.place = !is_valid || (key_q > cmd.key);
		flags.ge    = is_valid && (key_q >= cmd.key);
		flags.eq    = is_valid && (key_q == cmd.key);
	end

	always_ff @(posedge clk) begin
		if (cmd.ins && flags.place) begin
			key_q <= left_place ? left_key : cmd.key;
		end else if (cmd.del && flags.ge) begin
			key_q <= right_key;
		end
	end

endmodule

>>> rtl/sorted_list_table.sv
// Sorted key table, a row of compare-and-shift cells.
// Input stream s_*: tuser carries the mode (insert, delete, lookup, rewind,
// next), tdata the signed key. Output stream m_*: one result item per input
// item with status and found in tuser, and the entry read by next, the
// entry count and the full flag in tdata.
// Every cell compares the broadcast key with its own entry and shifts
// toward or away from its neighbor, so any operation completes in the
// cycle it is accepted. The result is registered; throughput is one item
// per cycle while the receiver takes results, as the cell row updates
// whole on acceptance. Delete and lookup decide presence by an OR over the
// cells' equal flags; next reads the entry under the cursor through one mux.
// Reset clears the count, the cursor and the output valid; entry contents
// are undefined until written and are never read beyond the count.
// When the receiver stalls the result holds in the output register and
// s_tready drops until it is taken; a new item is accepted in the cycle
// the pending result leaves.
module sorted_list_table (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [sltab_pkg::S_TDATA_W-1:0]   s_tdata,  // key
	input  logic [sltab_pkg::MODE_W-1:0]      s_tuser,  // mode
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [sltab_pkg::M_TDATA_W-1:0]   m_tdata,  // item_out, count, is_full, pad
	output logic [sltab_pkg::M_TUSER_W-1:0]   m_tuser   // status, found
);

	localparam int CAP = sltab_pkg::CAPACITY;
	localparam int KW  = sltab_pkg::KEY_W;
	localparam int CW  = sltab_pkg::CNT_W;

	logic                      acc;
	logic [sltab_pkg::MODE_W-1:0] mode;
	logic signed [KW-1:0]      key_in;
	logic [CW-1:0]             count_q;
	logic [CW-1:0]             cursor_q;
	logic                      full;
	logic                      found;
	logic                      cur_ok;
	logic [CAP-1:0]            eq_vec;

	sltab_pkg::sltab_cmd_t     cmd;
	sltab_pkg::sltab_flags_t   flags [CAP];
	logic signed [KW-1:0]      cell_key [CAP];

	logic                      m_tvalid_q;
	logic [sltab_pkg::STAT_W-1:0] status_q;
	logic                      found_q;
	logic signed [KW-1:0]      item_q;
	logic [CW-1:0]             count_out_q;
	logic                      full_out_q;

	logic [sltab_pkg::STAT_W-1:0] status_d;
	logic signed [KW-1:0]      item_d;
	logic [CW-1:0]             count_d;
	logic [CW-1:0]             cursor_d;

	assign s_tready = !m_tvalid_q || m_tready;
	assign acc      = s_tvalid && s_tready;
	assign mode     = s_tuser;
	assign key_in   = s_tdata[KW-1:0];
	assign full     = (count_q == CW'(CAP));
	assign found    = |eq_vec;
	assign cur_ok   = (cursor_q < count_q);

	assign cmd.ins = acc && (mode == sltab_pkg::MODE_INSERT) && !full;
	assign cmd.del = acc && (mode == sltab_pkg::MODE_DELETE) && found;
	assign cmd.key = key_in;

	for (genvar i = 0; i < CAP; i++) begin : g_cell
		logic signed [KW-1:0] lk;
		logic                 lp;
		logic signed [KW-1:0] rk;
		if (i == 0) begin : g_first
			assign lk = key_in;
			assign lp = 1'b0;
		end else begin : g_mid
			assign lk = cell_key[i-1];
			assign lp = flags[i-1].place;
		end
		if (i == CAP - 1) begin : g_last
			assign rk = cell_key[i];
		end else begin : g_inner
			assign rk = cell_key[i+1];
		end
		sltab_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.is_valid   (CW'(i) < count_q),
			.left_key   (lk),
			.left_place (lp),
			.right_key  (rk),
			.key_q      (cell_key[i]),
			.flags      (flags[i])
		);
		assign eq_vec[i] = flags[i].eq;
	end

	always_comb begin
		status_d = sltab_pkg::ST_OK;
		item_d   = '0;
		count_d  = count_q;
		cursor_d = cursor_q;
		case (mode)
			sltab_pkg::MODE_INSERT: begin
				if (full) begin
					status_d = sltab_pkg::ST_FULL;
				end else begin
					count_d = count_q + CW'(1);
				end
			end
			sltab_pkg::MODE_DELETE: begin
				if (found) begin
					count_d = count_q - CW'(1);
				end else begin
					status_d = sltab_pkg::ST_NOT_FOUND;
				end
			end
			sltab_pkg::MODE_LOOKUP: begin
				if (!found) begin
					status_d = sltab_pkg::ST_NOT_FOUND;
				end
			end
			sltab_pkg::MODE_REWIND: begin
				cursor_d = '0;
			end
			sltab_pkg::MODE_NEXT: begin
				if (cur_ok) begin
					item_d   = cell_key[cursor_q[sltab_pkg::IDX_W-1:0]];
					cursor_d = cursor_q + CW'(1);
				end else begin
					status_d = sltab_pkg::ST_AT_END;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			cursor_q   <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (acc) begin
				count_q    <= count_d;
				cursor_q   <= cursor_d;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			status_q    <= status_d;
			found_q     <= found && ((mode == sltab_pkg::MODE_DELETE) ||
			                         (mode == sltab_pkg::MODE_LOOKUP));
			item_q      <= item_d;
			count_out_q <= count_d;
			full_out_q  <= (count_d == CW'(CAP));
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = {found_q, status_q};
	assign m_tdata  = {{(sltab_pkg::M_TDATA_W - KW - CW - 1){1'b0}},
	                   full_out_q, count_out_q, item_q};

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAP))
		else $error("entry count above capacity");

	a_next_adv: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && (mode == sltab_pkg::MODE_NEXT) && cur_ok)
		|=> (cursor_q == $past(cursor_q) + CW'(1)))
		else $error("cursor did not advance on next");

	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && (mode == sltab_pkg::MODE_INSERT) && full)
		|=> ($stable(count_q) && (m_tuser[sltab_pkg::STAT_W-1:0] == sltab_pkg::ST_FULL)))
		else $error("insert into full table changed the count");
`endif

endmodule

>>> bench/tb_sorted_list_table.sv
`timescale 1ns / 100ps

module tb_sorted_list_table;
	import sltab_pkg::*;

	localparam logic [MODE_W-1:0] MODE_NOP_LO = 3'd5;
	localparam logic [MODE_W-1:0] MODE_NOP_HI = 3'd7;
	localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
	localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};
	localparam int RANDOM_ITEMS = 1250;
	localparam int LONG_HOLD    = 200;
	localparam int IDLE_LIMIT   = 4000;
	localparam int MAX_REPORTS  = 10;
	localparam int N_DIR        = 26;

	typedef enum int {STYLE_FILL, STYLE_DRAIN, STYLE_MIX, STYLE_SCAN} op_style_t;

	typedef struct packed {
		logic [STAT_W-1:0]       status;
		logic                    found;
		logic signed [KEY_W-1:0] item;
		logic [CNT_W-1:0]        count;
		logic                    full;
	} table_result_t;

	typedef struct {
		logic [MODE_W-1:0]       mode;
		logic signed [KEY_W-1:0] key;
		int                      reps;
		bit                      typed;
		table_result_t           want;
	} dir_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata;
	logic [MODE_W-1:0]     s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic [M_TUSER_W-1:0]  m_tuser;

	// shadow copy of the key table
	logic signed [KEY_W-1:0] shadow_keys [CAPACITY];
	int                      shadow_count = 0;
	int                      shadow_cursor = 0;
	table_result_t           result_q [$];

	dir_row_t dir_rows [N_DIR];
	int       burst_left = 0;
	bit       hold_req = 1'b0;
	int       n_errors = 0;
	int       n_checked = 0;
	int       idle_cycles = 0;
	int       mode_seen [8];
	int       n_full_rej = 0;
	int       n_absent = 0;
	int       n_past_end = 0;

	sorted_list_table dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #6 clk = ~clk;

	function automatic table_result_t table_apply(input logic [MODE_W-1:0] mode,
		input logic signed [KEY_W-1:0] k);
		table_result_t r;
		int pos;
		int j;
		r = '0;
		pos = 0;
		mode_seen[mode]++;
		case (mode)
		MODE_INSERT: begin
			if (shadow_count >= CAPACITY) begin
				r.status = ST_FULL;
				n_full_rej++;
			end else begin
				while (pos < shadow_count && !(shadow_keys[pos] > k))
					pos++;
				for (j = shadow_count; j > pos; j--)
					shadow_keys[j] = shadow_keys[j-1];
				shadow_keys[pos] = k;
				shadow_count++;
			end
		end
		MODE_DELETE, MODE_LOOKUP: begin
			while (pos < shadow_count && shadow_keys[pos] != k)
				pos++;
			if (pos >= shadow_count) begin
				r.status = ST_NOT_FOUND;
				n_absent++;
			end else begin
				r.found = 1'b1;
				if (mode == MODE_DELETE) begin
					for (j = pos; j + 1 < shadow_count; j++)
						shadow_keys[j] = shadow_keys[j+1];
					shadow_count--;
				end
			end
		end
		MODE_REWIND: shadow_cursor = 0;
		MODE_NEXT: begin
			if (shadow_cursor >= shadow_count) begin
				r.status = ST_AT_END;
				n_past_end++;
			end else begin
				r.item = shadow_keys[shadow_cursor];
				shadow_cursor++;
			end
		end
		default: ;
		endcase
		r.count = CNT_W'(shadow_count);
		r.full  = (shadow_count == CAPACITY);
		return r;
	endfunction

	function automatic logic signed [KEY_W-1:0] pick_key();
		int r;
		int v;
		r = $urandom_range(0, 99);
		if (r < 40 && shadow_count > 0)
			return shadow_keys[$urandom_range(0, shadow_count - 1)];
		if (r < 70) begin
			v = $urandom_range(0, 16);
			return v - 8;
		end
		if (r < 80) begin
			case ($urandom_range(0, 4))
			0: return KEY_MIN;
			1: return KEY_MAX;
			2: return KEY_MIN + 1;
			3: return KEY_MAX - 1;
			default: return -1;
			endcase
		end
		return $urandom;
	endfunction

	function automatic logic [MODE_W-1:0] pick_mode(input op_style_t style);
		int r;
		int lim [5];
		r = $urandom_range(0, 99);
		case (style)
		STYLE_FILL:  lim = '{60, 70, 82, 94, 98};
		STYLE_DRAIN: lim = '{12, 60, 78, 92, 97};
		default:     lim = '{30, 50, 70, 88, 96};
		endcase
		if (r < lim[0]) return MODE_INSERT;
		if (r < lim[1]) return MODE_DELETE;
		if (r < lim[2]) return MODE_LOOKUP;
		if (r < lim[3]) return MODE_NEXT;
		if (r < lim[4]) return MODE_REWIND;
		return MODE_W'(MODE_NOP_LO + $urandom_range(0, MODE_NOP_HI - MODE_NOP_LO));
	endfunction

	task automatic sender_rest(input int n);
		@(negedge clk);
		s_tvalid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic send_op(input logic [MODE_W-1:0] mode, input logic signed [KEY_W-1:0] k,
		input bit typed, input table_result_t want);
		table_result_t pred;
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0)
				sender_rest(gap);
		end
		burst_left--;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= k;
		do @(posedge clk); while (!s_tready);
		pred = table_apply(mode, k);
		result_q.push_back(typed ? want : pred);
	endtask

	// receiver: changing stall styles, plus one long hold on request
	initial begin
		int hold_left;
		int rx_left;
		int rx_style;
		int rx_tick;
		hold_left = 0;
		rx_left = 0;
		rx_style = 0;
		rx_tick = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			rx_tick++;
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (rx_left == 0) begin
				rx_left = $urandom_range(16, 96);
				rx_style = $urandom_range(0, 3);
			end
			rx_left--;
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				case (rx_style)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= ($urandom_range(0, 9) != 0);
				default: m_tready <= (rx_tick % 4 == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		table_result_t got;
		table_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.item   = m_tdata[KEY_W-1:0];
			got.count  = m_tdata[KEY_W +: CNT_W];
			got.full   = m_tdata[KEY_W + CNT_W];
			got.status = m_tuser[STAT_W-1:0];
			got.found  = m_tuser[STAT_W];
			if (result_q.size() == 0) begin
				n_errors++;
				if (n_errors <= MAX_REPORTS)
					$display({"%0t: unexpected result status %0d found %0d",
						" item %0d count %0d full %0d"},
						$realtime, got.status, got.found, got.item, got.count, got.full);
			end else begin
				want = result_q.pop_front();
				n_checked++;
				if (got.status !== want.status || got.found !== want.found ||
					got.item !== want.item || got.count !== want.count ||
					got.full !== want.full) begin
					n_errors++;
					if (n_errors <= MAX_REPORTS) begin
						$display("%0t: mismatch on result %0d", $realtime, n_checked);
						$display("  expected status %0d found %0d item %0d count %0d full %0d",
							want.status, want.found, want.item, want.count, want.full);
						$display("  actual   status %0d found %0d item %0d count %0d full %0d",
							got.status, got.found, got.item, got.count, got.full);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $realtime, IDLE_LIMIT);
				$display("sorted_list_table regression: fail");
				$finish;
			end
		end
	end

	initial begin
		int i;
		int n;
		int phase_len;
		int rnd_ops;
		bit hold_done;
		bit drain_done;
		op_style_t style;
		logic [MODE_W-1:0] mode;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		arst_n = 1'b0;
		rnd_ops = 0;
		hold_done = 1'b0;
		drain_done = 1'b0;
		foreach (mode_seen[i])
			mode_seen[i] = 0;
		dir_rows = '{
			'{MODE_NEXT,   0,       1,  1'b1, '{ST_AT_END,    1'b0, 0,       0,  1'b0}},
			'{MODE_DELETE, 5,       1,  1'b1, '{ST_NOT_FOUND, 1'b0, 0,       0,  1'b0}},
			'{MODE_LOOKUP, 0,       1,  1'b1, '{ST_NOT_FOUND, 1'b0, 0,       0,  1'b0}},
			'{MODE_INSERT, KEY_MIN, 1,  1'b1, '{ST_OK,        1'b0, 0,       1,  1'b0}},
			'{MODE_INSERT, KEY_MAX, 1,  1'b1, '{ST_OK,        1'b0, 0,       2,  1'b0}},
			'{MODE_INSERT, 0,       1,  1'b0, '0},
			'{MODE_INSERT, 0,       1,  1'b0, '0},
			'{MODE_INSERT, -1,      1,  1'b0, '0},
			'{MODE_LOOKUP, KEY_MAX, 1,  1'b0, '0},
			'{MODE_LOOKUP, 1,       1,  1'b1, '{ST_NOT_FOUND, 1'b0, 0,       5,  1'b0}},
			'{MODE_NEXT,   0,       1,  1'b1, '{ST_OK,        1'b0, KEY_MIN, 5,  1'b0}},
			'{MODE_NEXT,   KEY_MAX, 2,  1'b0, '0},
			// delete below the cursor: entries slide past it
			'{MODE_DELETE, KEY_MIN, 1,  1'b0, '0},
			'{MODE_NEXT,   -1,      1,  1'b0, '0},
			'{MODE_NOP_LO, 123,     1,  1'b0, '0},
			'{MODE_NOP_HI, -1,      1,  1'b0, '0},
			'{MODE_REWIND, KEY_MIN, 1,  1'b0, '0},
			'{MODE_DELETE, 0,       1,  1'b0, '0},
			'{MODE_INSERT, 100,     13, 1'b0, '0},
			'{MODE_INSERT, 7,       1,  1'b1, '{ST_FULL,      1'b0, 0,       16, 1'b1}},
			'{MODE_DELETE, 42,      1,  1'b1, '{ST_NOT_FOUND, 1'b0, 0,       16, 1'b1}},
			'{MODE_NEXT,   0,       16, 1'b0, '0},
			'{MODE_NEXT,   0,       1,  1'b1, '{ST_AT_END,    1'b0, 0,       16, 1'b1}},
			'{MODE_LOOKUP, KEY_MIN, 1,  1'b1, '{ST_NOT_FOUND, 1'b0, 0,       16, 1'b1}},
			'{MODE_DELETE, KEY_MAX, 1,  1'b0, '0},
			'{MODE_INSERT, KEY_MIN, 1,  1'b0, '0}
		};

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (i = 0; i < N_DIR; i++)
			repeat (dir_rows[i].reps)
				send_op(dir_rows[i].mode, dir_rows[i].key, dir_rows[i].typed, dir_rows[i].want);

		while (rnd_ops < RANDOM_ITEMS) begin
			style = op_style_t'($urandom_range(0, 3));
			phase_len = $urandom_range(30, 120);
			for (n = 0; n < phase_len && rnd_ops < RANDOM_ITEMS; n++) begin
				if (style == STYLE_SCAN) begin
					if (n == 0 || $urandom_range(0, 19) == 0)
						mode = MODE_REWIND;
					else if ($urandom_range(0, 9) == 0)
						mode = pick_mode(STYLE_MIX);
					else
						mode = MODE_NEXT;
				end else begin
					mode = pick_mode(style);
				end
				send_op(mode, pick_key(), 1'b0, '0);
				if (mode <= MODE_NEXT)
					rnd_ops++;
				if (!hold_done && rnd_ops >= RANDOM_ITEMS / 3) begin
					hold_req = 1'b1;
					hold_done = 1'b1;
				end
				if (!drain_done && rnd_ops >= 2 * RANDOM_ITEMS / 3) begin
					sender_rest(1);
					while (result_q.size() != 0)
						@(posedge clk);
					drain_done = 1'b1;
				end
			end
		end

		sender_rest(1);
		while (result_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display({"items by mode: insert %0d, delete %0d, lookup %0d,",
			" rewind %0d, next %0d, unused %0d"},
			mode_seen[MODE_INSERT], mode_seen[MODE_DELETE], mode_seen[MODE_LOOKUP],
			mode_seen[MODE_REWIND], mode_seen[MODE_NEXT],
			mode_seen[5] + mode_seen[6] + mode_seen[7]);
		$display("%0d full rejections, %0d absent keys, %0d reads past end; %0d results, %0d bad",
			n_full_rej, n_absent, n_past_end, n_checked, n_errors);
		if (n_errors == 0 && result_q.size() == 0) begin
			$display("sorted_list_table regression: pass");
		end else begin
			$display("sorted_list_table regression: fail");
		end
		$finish;
	end

endmodule
